### hdl/mide_pkg.sv
`default_nettype none
package mide_pkg;

  // Configuration register map.
  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned AXIS_N     = 3;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_CELL_X   = 2'd0,
    CFG_CELL_Y   = 2'd1,
    CFG_CELL_Z   = 2'd2,
    CFG_PER_MASK = 2'd3
  } cfg_reg_e;

  // Reset values: a cell of 1.0 in Q16.16 on every axis, all axes periodic.
  localparam logic [30:0]       CELL_RESET = 31'd65536;
  localparam logic [AXIS_N-1:0] MASK_RESET = 3'b111;

endpackage
`default_nettype wire

### hdl/mide_lane.sv
`default_nettype none
module mide_lane #(
  parameter int unsigned COORD_WIDTH = 32
) (
  input  wire logic                         clk_i,
  input  wire logic                         en_i,
  input  wire logic signed [COORD_WIDTH-1:0] p_i,
  input  wire logic signed [COORD_WIDTH-1:0] q_i,
  input  wire logic [COORD_WIDTH-2:0]       cell_i,
  input  wire logic                         per_i,
  output logic [COORD_WIDTH:0]              delta_o,
  output logic [2*COORD_WIDTH+1:0]          sq_o
);
  localparam int unsigned DW  = COORD_WIDTH + 1;
  localparam int unsigned CLW = COORD_WIDTH - 1;

  logic [DW-1:0]  mag_q  [0:DW];
  logic [DW-1:0]  sh_q   [0:DW];
  logic [CLW-1:0] rem_q  [0:DW];
  logic [CLW-1:0] cell_q [0:DW];
  logic           neg_q  [0:DW];
  logic           per_q  [0:DW];

  logic signed [DW-1:0] diff;
  logic [DW-1:0]        diff_mag;

  // Exact difference and its magnitude.
  always_comb begin
    diff     = $signed({p_i[COORD_WIDTH-1], p_i}) - $signed({q_i[COORD_WIDTH-1], q_i});
    diff_mag = diff[DW-1] ? DW'(-diff) : DW'(diff);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_q[0]  <= diff_mag;
      sh_q[0]   <= diff_mag;
      rem_q[0]  <= '0;
      cell_q[0] <= cell_i;
      neg_q[0]  <= diff[DW-1];
      per_q[0]  <= per_i;
    end
  end

  // Restoring division of the magnitude by the cell, one dividend bit a stage.
  for (genvar k = 1; k <= DW; k++) begin : g_div
    logic [CLW:0] trial;
    logic [CLW:0] trial_sub;
    always_comb begin
      trial     = {rem_q[k-1], sh_q[k-1][DW-1]};
      trial_sub = trial - {1'b0, cell_q[k-1]};
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= (trial >= {1'b0, cell_q[k-1]}) ? trial_sub[CLW-1:0] : trial[CLW-1:0];
        sh_q[k]   <= {sh_q[k-1][DW-2:0], 1'b0};
        mag_q[k]  <= mag_q[k-1];
        cell_q[k] <= cell_q[k-1];
        neg_q[k]  <= neg_q[k-1];
        per_q[k]  <= per_q[k-1];
      end
    end
  end

  // Signed remainder folded into half a cell; the raw difference if aperiodic.
  logic [DW:0]          rv;
  logic signed [DW:0]   sv;
  logic signed [DW+1:0] twice;
  logic signed [DW+1:0] cext;
  logic signed [DW:0]   folded;
  logic [DW-1:0]        fold_q;

  always_comb begin
    rv     = per_q[DW] ? (DW+1)'(rem_q[DW]) : {1'b0, mag_q[DW]};
    sv     = neg_q[DW] ? -$signed(rv) : $signed(rv);
    twice  = $signed({sv, 1'b0});
    cext   = $signed((DW+2)'(cell_q[DW]));
    folded = sv;
    if (per_q[DW]) begin
      if (twice > cext) begin
        folded = sv - $signed((DW+1)'(cell_q[DW]));
      end else if (twice < -cext) begin
        folded = sv + $signed((DW+1)'(cell_q[DW]));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      fold_q <= folded[DW-1:0];
    end
  end

  // Square of the folded component.
  logic [DW-1:0] fmag;
  always_comb begin
    fmag = fold_q[DW-1] ? DW'(-$signed(fold_q)) : fold_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      delta_o <= fold_q;
      sq_o    <= fmag * fmag;
    end
  end

endmodule
`default_nettype wire

### hdl/mide_merge.sv
`default_nettype none
module mide_merge #(
  parameter int unsigned COORD_WIDTH = 32
) (
  input  wire logic                       clk_i,
  input  wire logic                       en_i,
  input  wire logic [COORD_WIDTH:0]       dx_i,
  input  wire logic [COORD_WIDTH:0]       dy_i,
  input  wire logic [COORD_WIDTH:0]       dz_i,
  input  wire logic [2*COORD_WIDTH+1:0]   sqx_i,
  input  wire logic [2*COORD_WIDTH+1:0]   sqy_i,
  input  wire logic [2*COORD_WIDTH+1:0]   sqz_i,
  output logic [COORD_WIDTH:0]            dx_o,
  output logic [COORD_WIDTH:0]            dy_o,
  output logic [COORD_WIDTH:0]            dz_o,
  output logic [COORD_WIDTH:0]            sep_o
);
  localparam int unsigned DW = COORD_WIDTH + 1;
  localparam int unsigned SW = 2 * DW + 2;
  localparam int unsigned RB = DW + 1;

  logic [SW-1:0] rem_q  [0:RB];
  logic [RB-1:0] root_q [0:RB];
  logic [DW-1:0] dx_q   [0:RB];
  logic [DW-1:0] dy_q   [0:RB];
  logic [DW-1:0] dz_q   [0:RB];

  // Sum of the three squares.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= SW'(sqx_i) + SW'(sqy_i) + SW'(sqz_i);
      root_q[0] <= '0;
      dx_q[0]   <= dx_i;
      dy_q[0]   <= dy_i;
      dz_q[0]   <= dz_i;
    end
  end

  // Bitwise integer square root, one result bit a stage from the top.
  for (genvar j = 1; j <= RB; j++) begin : g_sqrt
    localparam int unsigned B = RB - j;
    logic [SW-1:0] trial;
    always_comb begin
      trial = (SW'(root_q[j-1]) << (B + 1)) + (SW'(1) << (2 * B));
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (rem_q[j-1] >= trial) begin
          rem_q[j]  <= rem_q[j-1] - trial;
          root_q[j] <= root_q[j-1] | (RB'(1) << B);
        end else begin
          rem_q[j]  <= rem_q[j-1];
          root_q[j] <= root_q[j-1];
        end
        dx_q[j] <= dx_q[j-1];
        dy_q[j] <= dy_q[j-1];
        dz_q[j] <= dz_q[j-1];
      end
    end
  end

  assign dx_o  = dx_q[RB];
  assign dy_o  = dy_q[RB];
  assign dz_o  = dz_q[RB];
  assign sep_o = root_q[RB][DW-1:0];

endmodule
`default_nettype wire

### hdl/periodic_minimum_image_distance_core.sv
// Minimum-image separation of two points in a periodic 3D cell.
// Slave stream: one request per pair, tdata carries first_x, first_y, first_z,
// second_x, second_y, second_z (signed Q16.16). Master stream: one result per
// request, tdata carries delta_x, delta_y, delta_z and separation.
// Configuration: cell lengths and the periodic axis mask are written through
// cfg_we_i / cfg_addr_i / cfg_wdata_i; the user must write them only while no
// request is in flight, which the block does not enforce. Throughput: one
// request per cycle while the output is not stalled. Most of the pipeline is
// the per-axis restoring divider (one stage per difference bit) and the
// square-root pipeline (one stage per root bit). Three axis lanes run side by
// side; a merging block sums the squares and takes the root. The whole
// pipeline advances together: when the output holds a result that the
// receiver does not take, every stage holds and s_axis_tready falls. Reset
// empties the pipeline and loads cells of 1.0 with all three axes periodic.
`default_nettype none
module periodic_minimum_image_distance_core #(
  parameter int unsigned COORD_WIDTH = 32
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 s_axis_tvalid,
  output logic                                      s_axis_tready,
  // first_x, first_y, first_z, second_x, second_y, second_z, zero pad
  input  wire logic [((6*COORD_WIDTH+7)/8)*8-1:0]   s_axis_tdata,
  output logic                                      m_axis_tvalid,
  input  wire logic                                 m_axis_tready,
  // delta_x, delta_y, delta_z, separation, zero pad
  output logic [((4*COORD_WIDTH+11)/8)*8-1:0]       m_axis_tdata,
  input  wire logic                                 cfg_we_i,
  input  wire mide_pkg::cfg_reg_e                   cfg_addr_i,
  input  wire logic [COORD_WIDTH-2:0]               cfg_wdata_i
);
  import mide_pkg::*;

  localparam int unsigned CW    = COORD_WIDTH;
  localparam int unsigned DW    = CW + 1;
  localparam int unsigned CLW   = CW - 1;
  localparam int unsigned OUT_W = ((4*CW+11)/8)*8;
  localparam int unsigned LAT   = 2 * DW + 5;

  logic [CLW-1:0]    cell_q [0:AXIS_N-1];
  logic [AXIS_N-1:0] mask_q;
  logic [LAT-1:0]    vld_q;
  logic              adv;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < AXIS_N; a++) begin
        cell_q[a] <= CLW'(CELL_RESET);
      end
      mask_q <= MASK_RESET;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_CELL_X:   cell_q[0] <= cfg_wdata_i;
        CFG_CELL_Y:   cell_q[1] <= cfg_wdata_i;
        CFG_CELL_Z:   cell_q[2] <= cfg_wdata_i;
        CFG_PER_MASK: mask_q    <= cfg_wdata_i[AXIS_N-1:0];
        default: ;
      endcase
    end
  end

  // The pipeline moves whenever the output stage is empty or being drained.
  assign adv           = !vld_q[LAT-1] || m_axis_tready;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = vld_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[LAT-2:0], s_axis_tvalid};
    end
  end

  // One lane per axis.
  logic [DW-1:0]   delta [0:AXIS_N-1];
  logic [2*DW-1:0] sq    [0:AXIS_N-1];

  for (genvar a = 0; a < AXIS_N; a++) begin : g_lane
    mide_lane #(.COORD_WIDTH(CW)) u_lane (
      .clk_i   (clk_i),
      .en_i    (adv),
      .p_i     ($signed(s_axis_tdata[a*CW +: CW])),
      .q_i     ($signed(s_axis_tdata[(a+3)*CW +: CW])),
      .cell_i  (cell_q[a]),
      .per_i   (mask_q[a] && (cell_q[a] != '0)),
      .delta_o (delta[a]),
      .sq_o    (sq[a])
    );
  end

  logic [DW-1:0] dx, dy, dz, sep;

  mide_merge #(.COORD_WIDTH(CW)) u_merge (
    .clk_i (clk_i),
    .en_i  (adv),
    .dx_i  (delta[0]),
    .dy_i  (delta[1]),
    .dz_i  (delta[2]),
    .sqx_i (sq[0]),
    .sqy_i (sq[1]),
    .sqz_i (sq[2]),
    .dx_o  (dx),
    .dy_o  (dy),
    .dz_o  (dz),
    .sep_o (sep)
  );

  assign m_axis_tdata = OUT_W'({sep, dz, dy, dx});

  // Input is refused only while a finished result is held back.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without a blocked result");

  // A zero separation vector gives a zero distance.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && dx == '0 && dy == '0 && dz == '0) |-> (sep == '0))
    else $error("nonzero distance for zero separation");

  // A write to the x cell lands in its register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_we_i && cfg_addr_i == CFG_CELL_X) |=> (cell_q[0] == $past(cfg_wdata_i)))
    else $error("cell_x write lost");

endmodule
`default_nettype wire
